### hw/rtl/b64_pkg.sv
// Shared types, constants and the character table for the Base64 encoder.
// Used by every module under hw/rtl; depends on nothing else.
package b64_pkg;

  // Default depth of the group queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int GROUP_W = 24;
  localparam int SEXTET_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR = 7'h2B;
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2F;
  localparam logic [SEXTET_W-1:0] SIX_MASK = 6'h3F;

  // How a queued group is rendered
  typedef enum logic [1:0] {
    GRP_FULL, // three bytes, four characters
    GRP_PAD1, // two bytes, one trailing '='
    GRP_PAD2  // one byte, two trailing '='
  } grp_kind_t;

  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    grp_kind_t          kind;
    logic               last;
  } group_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXTET_W-1:0] idx);
    logic [CHAR_W-1:0] code;
    if (idx < 6'd26) begin
      code = 7'(idx) + 7'h41;
    end else if (idx < 6'd52) begin
      code = 7'(idx - 6'd26) + 7'h61;
    end else if (idx < 6'd62) begin
      code = 7'(idx - 6'd52) + 7'h30;
    end else if (idx == 6'd62) begin
      code = PLUS_CHAR;
    end else begin
      code = SLASH_CHAR;
    end
    return code;
  endfunction

endpackage

### hw/rtl/base64_encoder_core.sv
// Base64 encoder (standard alphabet, '=' padding) with stream ports.
// Top level: instantiates b64_front, b64_queue and b64_back; depends on b64_pkg.
//
// Raw bytes enter on the s_ side with tlast on the final byte of a message;
// ASCII characters leave on the m_ side, tlast on the final character. Each
// third byte, or a final byte, yields four characters. The input takes one
// word per cycle while the group queue has room; the output register emits one
// character per cycle while the queue is not empty and m_tready allows, so the
// single character register, not the input, sets the sustained rate. A byte that
// completes a group is written into the group queue, and its first character then
// passes through the output register. The queue holds QUEUE_DEPTH groups.
module base64_encoder_core #(
  parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
  output logic       m_tlast    // last_char
);
  import b64_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          push;
  group_t        push_grp;
  logic          pop;
  group_t        head;
  q_stat_t       q_stat;
  logic [CW-1:0] q_count;

  b64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_grp (push_grp)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat),
    .count    (q_count)
  );

  b64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("group queue overfilled");

  // Nothing pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full queue");

  // A pushed group appears in the count next cycle unless one also leaves
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (q_count == $past(q_count) + CW'(1)))
    else $error("queue count lost a group");

  // Output words are always 7-bit ASCII
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7])
    else $error("non-ASCII output word");

endmodule

### hw/rtl/b64_front.sv
// Front end of the Base64 encoder: takes bytes, assembles 3-byte groups or a padded final group.
// Depends on b64_pkg.
module b64_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] data_byte
  input  logic                s_tlast,   // last_byte
  input  b64_pkg::q_stat_t    q_stat,
  output logic                push,
  output b64_pkg::group_t     push_grp
);
  import b64_pkg::*;

  logic [7:0] held_bytes [2];
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic       accept;

  // Take a word whenever the queue has a free slot
  assign s_tready = !q_stat.full;
  assign accept = s_tvalid && s_tready;

  // Classify: complete group, padded tail, or hold
  always_comb begin
    push = 1'b0;
    push_grp.bits = {held_bytes[0], held_bytes[1], s_tdata};
    push_grp.kind = GRP_FULL;
    push_grp.last = s_tlast;
    held_count_next = held_count;
    if (accept) begin
      if (held_count == 2'd2) begin
        push = 1'b1;
        held_count_next = 2'd0;
      end else if (s_tlast) begin
        push = 1'b1;
        held_count_next = 2'd0;
        if (held_count == 2'd0) begin
          push_grp.bits = {s_tdata, 16'h0000};
          push_grp.kind = GRP_PAD2;
        end else begin
          push_grp.bits = {held_bytes[0], s_tdata, 8'h00};
          push_grp.kind = GRP_PAD1;
        end
      end else begin
        held_count_next = held_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else begin
      held_count <= held_count_next;
    end
  end

  // Pending bytes, no reset needed
  always_ff @(posedge clk) begin
    if (accept && !s_tlast && held_count != 2'd2) begin
      held_bytes[held_count[0]] <= s_tdata;
    end
  end

endmodule

### hw/rtl/b64_queue.sv
// Short group queue between the front and back of the Base64 encoder.
// Depends on b64_pkg.
module b64_queue #(
  parameter int DEPTH = b64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  b64_pkg::group_t               push_grp,
  input  logic                          pop,
  output b64_pkg::group_t               head,
  output b64_pkg::q_stat_t              q_stat,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import b64_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t          slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW-1:0]   wr_ptr_next;
  logic [AW-1:0]   rd_ptr_next;
  logic [CW-1:0]   count_next;

  assign q_stat.full = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign head = slots[rd_ptr];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    count_next = count + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_grp;
    end
  end

endmodule

### hw/rtl/b64_back.sv
// Back end of the Base64 encoder: renders queued groups, one character a cycle
// while the queue is not empty and m_tready allows. Depends on b64_pkg.
module b64_back (
  input  logic                clk,
  input  logic                rst,
  input  b64_pkg::group_t     head,
  input  b64_pkg::q_stat_t    q_stat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [6:0] char_code, [7] zero
  output logic                m_tlast    // last_char
);
  import b64_pkg::*;

  logic [1:0]          pos;
  logic                advance;
  logic                load;
  logic [SEXTET_W-1:0] sextet;
  logic                is_pad;
  logic [CHAR_W-1:0]   char_next;

  // Output register moves when empty or taken
  assign advance = !m_tvalid || m_tready;
  assign load = advance && !q_stat.empty;
  assign pop = load && (pos == 2'd3);

  // Pick the sextet for this position, most significant first
  always_comb begin
    case (pos)
      2'd0: sextet = head.bits[23:18];
      2'd1: sextet = head.bits[17:12];
      2'd2: sextet = head.bits[11:6];
      2'd3: sextet = head.bits[5:0];
      default: sextet = '0;
    endcase
    sextet = sextet & SIX_MASK;
    case (head.kind)
      GRP_PAD1: is_pad = (pos == 2'd3);
      GRP_PAD2: is_pad = (pos[1] == 1'b1);
      default:  is_pad = 1'b0;
    endcase
    char_next = is_pad ? PAD_CHAR : b64_char(sextet);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pos <= pos + 2'd1;
      end
      if (advance) begin
        m_tvalid <= !q_stat.empty;
      end
    end
  end

  // Character word register
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, char_next};
      m_tlast <= head.last && (pos == 2'd3);
    end
  end

endmodule
